/* sv/slcfc_pkg.sv */
package slcfc_pkg;

   localparam int BYTE_W   = 8;
   localparam int OFFSET_W = 17;
   localparam int HDR_LEN  = 28;
   localparam int OVERHEAD = 32;

   localparam logic [BYTE_W-1:0] SYNC0 = 8'hAA;
   localparam logic [BYTE_W-1:0] SYNC1 = 8'h44;
   localparam logic [BYTE_W-1:0] SYNC2 = 8'h12;

   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [OFFSET_W-1:0] MAX_LEN_RESET = 17'd10240;

   typedef enum logic [1:0] {
      STATUS_NONE     = 2'd0,
      STATUS_GOOD     = 2'd1,
      STATUS_CRC_BAD  = 2'd2,
      STATUS_TOO_LONG = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      PH_HUNT  = 2'b01,
      PH_FRAME = 2'b10
   } phase_type;

   // reflected crc-32, one byte, eight unrolled bit steps
   function automatic logic [31:0] crc32_byte(input logic [31:0] crc_i,
                                              input logic [BYTE_W-1:0] data_i);
      logic [31:0] c;
      c = crc_i ^ {24'd0, data_i};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   localparam logic [31:0] CRC_SEED =
      crc32_byte(crc32_byte(crc32_byte(32'd0, SYNC0), SYNC1), SYNC2);

endpackage

/* sv/slcfc_if.sv */
interface slcfc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface slcfc_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic        in_frame;
   logic [16:0] byte_offset;
   logic        frame_end;
   logic [1:0]  status;
   logic [15:0] msg_id;
   logic [15:0] payload_len;
   logic [1:0]  msg_format;
   logic [15:0] gps_week;
   logic [31:0] gps_ms;

   modport source (output valid, output data_byte, output in_frame, output byte_offset,
                   output frame_end, output status, output msg_id, output payload_len,
                   output msg_format, output gps_week, output gps_ms, input ready);
   modport sink (input valid, input data_byte, input in_frame, input byte_offset,
                 input frame_end, input status, input msg_id, input payload_len,
                 input msg_format, input gps_week, input gps_ms, output ready);
endinterface

interface slcfc_csr_if;
   logic        valid;
   logic        ready;
   logic [16:0] max_frame_len;

   modport source (output valid, output max_frame_len, input ready);
   modport sink (input valid, input max_frame_len, output ready);
endinterface

/* sv/sync_length_crc32_frame_checker.sv */
// the response is registered and shows in the cycle after its request is accepted
// throughput: one byte per cycle when not stalled; crc update is eight unrolled bit steps
// a request is taken only when the response register is empty or empties in the same cycle,
// so a stalled response holds off the next request
// reset (synchronous, active high) returns to sync hunting, clears the header and crc
// registers, empties the response register and sets the frame limit to 10240
module sync_length_crc32_frame_checker (
   input  logic        clock,
   input  logic        reset,
   slcfc_req_if.sink   req_ch,
   slcfc_rsp_if.source rsp_ch,
   slcfc_csr_if.sink   csr_ch
);
   import slcfc_pkg::*;

   phase_type           phase_ff, phase_in;
   logic [15:0]         hist_ff, hist_in;
   logic [OFFSET_W-1:0] count_ff, count_in;
   logic [15:0]         len_ff, len_in;
   logic [15:0]         id_ff, id_in;
   logic [15:0]         week_ff, week_in;
   logic [31:0]         ms_ff, ms_in;
   logic [1:0]          fmt_ff, fmt_in;
   logic [31:0]         crc_ff, crc_in;
   logic [31:0]         rcrc_ff, rcrc_in;
   logic [OFFSET_W-1:0] max_len_ff;

   logic                rsp_valid_ff;
   logic [7:0]          data_ff;
   logic                inf_ff;
   logic [OFFSET_W-1:0] off_ff;
   logic                fend_ff;
   status_type          status_ff;
   logic [15:0]         out_id_ff, out_len_ff, out_week_ff;
   logic [1:0]          out_fmt_ff;
   logic [31:0]         out_ms_ff;

   logic                req_fire;
   logic [7:0]          b;
   logic                inf;
   logic [OFFSET_W-1:0] off;
   logic                fend;
   status_type          status;
   logic [OFFSET_W-1:0] body_end;
   logic [OFFSET_W-1:0] crc_pos;
   logic [OFFSET_W-1:0] need_len;

   assign req_ch.ready = !reset && (!rsp_valid_ff || rsp_ch.ready);
   assign csr_ch.ready = !reset;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign b            = req_ch.rx_byte;

   always_comb begin
      phase_in = phase_ff;
      hist_in  = hist_ff;
      count_in = count_ff;
      len_in   = len_ff;
      id_in    = id_ff;
      week_in  = week_ff;
      ms_in    = ms_ff;
      fmt_in   = fmt_ff;
      crc_in   = crc_ff;
      rcrc_in  = rcrc_ff;
      inf      = 1'b0;
      off      = '0;
      fend     = 1'b0;
      status   = STATUS_NONE;
      body_end = '0;
      crc_pos  = '0;
      need_len = '0;
      unique case (phase_ff)
         PH_HUNT: begin
            if (hist_ff == {SYNC0, SYNC1} && b == SYNC2) begin
               inf      = 1'b1;
               off      = OFFSET_W'(2);
               len_in   = '0;
               id_in    = '0;
               week_in  = '0;
               ms_in    = '0;
               fmt_in   = '0;
               rcrc_in  = '0;
               crc_in   = CRC_SEED;
               count_in = OFFSET_W'(3);
               phase_in = PH_FRAME;
               hist_in  = '0;
            end else begin
               hist_in = {hist_ff[7:0], b};
            end
         end
         PH_FRAME: begin
            inf = 1'b1;
            off = count_ff;
            unique case (off)
               OFFSET_W'(4):  id_in[7:0]    = b;
               OFFSET_W'(5):  id_in[15:8]   = b;
               OFFSET_W'(6):  fmt_in        = b[5:4];
               OFFSET_W'(8):  len_in[7:0]   = b;
               OFFSET_W'(9):  len_in[15:8]  = b;
               OFFSET_W'(14): week_in[7:0]  = b;
               OFFSET_W'(15): week_in[15:8] = b;
               OFFSET_W'(16): ms_in[7:0]    = b;
               OFFSET_W'(17): ms_in[15:8]   = b;
               OFFSET_W'(18): ms_in[23:16]  = b;
               OFFSET_W'(19): ms_in[31:24]  = b;
               default: ;
            endcase
            body_end = {1'b0, len_in} + OFFSET_W'(HDR_LEN);
            need_len = {1'b0, len_in} + OFFSET_W'(OVERHEAD);
            crc_pos  = off - body_end;
            if (off < body_end) begin
               crc_in = crc32_byte(crc_ff, b);
            end else begin
               // crc bytes arrive little-endian
               rcrc_in = rcrc_ff | ({24'd0, b} << {crc_pos[1:0], 3'b000});
            end
            if (off == OFFSET_W'(9) && need_len > max_len_ff) begin
               fend   = 1'b1;
               status = STATUS_TOO_LONG;
            end else if (off >= OFFSET_W'(HDR_LEN) && off >= body_end + OFFSET_W'(3)) begin
               fend   = 1'b1;
               status = (crc_ff == rcrc_in) ? STATUS_GOOD : STATUS_CRC_BAD;
            end
            if (fend) begin
               phase_in = PH_HUNT;
               count_in = '0;
               hist_in  = '0;
            end else begin
               count_in = off + OFFSET_W'(1);
            end
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT;
         hist_ff    <= '0;
         count_ff   <= '0;
         len_ff     <= '0;
         id_ff      <= '0;
         week_ff    <= '0;
         ms_ff      <= '0;
         fmt_ff     <= '0;
         crc_ff     <= '0;
         rcrc_ff    <= '0;
         max_len_ff <= MAX_LEN_RESET;
      end else begin
         if (req_fire) begin
            phase_ff <= phase_in;
            hist_ff  <= hist_in;
            count_ff <= count_in;
            len_ff   <= len_in;
            id_ff    <= id_in;
            week_ff  <= week_in;
            ms_ff    <= ms_in;
            fmt_ff   <= fmt_in;
            crc_ff   <= crc_in;
            rcrc_ff  <= rcrc_in;
         end
         if (csr_ch.valid && csr_ch.ready) begin
            max_len_ff <= csr_ch.max_frame_len;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // header fields read as zero outside a frame
   always_ff @(posedge clock) begin
      if (req_fire) begin
         data_ff     <= b;
         inf_ff      <= inf;
         off_ff      <= off;
         fend_ff     <= fend;
         status_ff   <= status;
         out_id_ff   <= inf ? id_in : 16'd0;
         out_len_ff  <= inf ? len_in : 16'd0;
         out_fmt_ff  <= inf ? fmt_in : 2'd0;
         out_week_ff <= inf ? week_in : 16'd0;
         out_ms_ff   <= inf ? ms_in : 32'd0;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.data_byte   = data_ff;
   assign rsp_ch.in_frame    = inf_ff;
   assign rsp_ch.byte_offset = off_ff;
   assign rsp_ch.frame_end   = fend_ff;
   assign rsp_ch.status      = status_ff;
   assign rsp_ch.msg_id      = out_id_ff;
   assign rsp_ch.payload_len = out_len_ff;
   assign rsp_ch.msg_format  = out_fmt_ff;
   assign rsp_ch.gps_week    = out_week_ff;
   assign rsp_ch.gps_ms      = out_ms_ff;

endmodule

/* sv/slcfc_checker.sv */
module slcfc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_in_frame,
   input logic [16:0] rsp_byte_offset,
   input logic        rsp_frame_end,
   input logic [1:0]  rsp_status,
   input logic [15:0] rsp_msg_id
);
   import slcfc_pkg::*;

   // every accepted request shows a response on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted request produced no response");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_in_frame |-> rsp_byte_offset == 17'd0 && rsp_msg_id == 16'd0
         && !rsp_frame_end && rsp_status == STATUS_NONE)
      else $error("hunting byte carries frame information");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_frame_end == (rsp_status != STATUS_NONE))
      else $error("frame end and status disagree");

   // the last byte of a good or failed frame is never before offset 31
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_GOOD || rsp_status == STATUS_CRC_BAD)
         |-> rsp_byte_offset >= 17'd31)
      else $error("crc frame end too early");

endmodule

bind sync_length_crc32_frame_checker slcfc_checker u_slcfc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_in_frame    (rsp_ch.in_frame),
   .rsp_byte_offset (rsp_ch.byte_offset),
   .rsp_frame_end   (rsp_ch.frame_end),
   .rsp_status      (rsp_ch.status),
   .rsp_msg_id      (rsp_ch.msg_id)
);

/* tb/tb_sync_length_crc32_frame_checker.sv */
`timescale 1ns / 100ps

module tb_sync_length_crc32_frame_checker;
   import slcfc_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 2_000_000;
   localparam int unsigned PHASE_BYTES = 210;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        in_frame;
      logic [16:0] byte_offset;
      logic        frame_end;
      status_type  status;
      logic [15:0] msg_id;
      logic [15:0] payload_len;
      logic [1:0]  msg_format;
      logic [15:0] gps_week;
      logic [31:0] gps_ms;
   } echo_item_type;

   logic clock = 1'b0;
   logic reset;

   slcfc_req_if req_ch();
   slcfc_rsp_if rsp_ch();
   slcfc_csr_if csr_ch();

   sync_length_crc32_frame_checker DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #4 clock = ~clock;

   // frame tracker state, mirrors the block after each accepted request
   bit          capturing   = 1'b0;
   logic [15:0] hunt_window = '0;
   logic [16:0] next_offset = '0;
   logic [15:0] hdr_id      = '0;
   logic [15:0] hdr_len     = '0;
   logic [1:0]  hdr_fmt     = '0;
   logic [15:0] hdr_week    = '0;
   logic [31:0] hdr_ms      = '0;
   logic [31:0] crc_run     = '0;
   logic [31:0] crc_rx      = '0;
   logic [16:0] frame_limit = MAX_LEN_RESET;

   echo_item_type expected_echoes[$];
   echo_item_type oldest_echo;
   logic [7:0]  frame_buf[$];
   int unsigned mismatch_count = 0;
   int unsigned cycle_count    = 0;
   int unsigned bytes_sent     = 0;
   int unsigned sink_hold      = 0;
   bit          src_idle_on    = 1'b1;
   bit          sink_stall_on  = 1'b1;

   function automatic logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] d);
      logic [31:0] r;
      r = c;
      for (int i = 0; i < 8; i++) begin
         r = (r >> 1) ^ ({32{r[0] ^ d[i]}} & 32'hEDB88320);
      end
      return r;
   endfunction

   task automatic track_frame_byte(input logic [7:0] b);
      echo_item_type e;
      int unsigned off;
      int unsigned body_end;
      e = '0;
      e.data_byte = b;
      if (!capturing) begin
         if (hunt_window == {SYNC0, SYNC1} && b == SYNC2) begin
            e.in_frame  = 1'b1;
            e.byte_offset = 17'd2;
            hdr_id = '0;
            hdr_len = '0;
            hdr_fmt = '0;
            hdr_week = '0;
            hdr_ms = '0;
            crc_rx = '0;
            crc_run = crc_next(crc_next(crc_next(32'd0, SYNC0), SYNC1), SYNC2);
            next_offset = 17'd3;
            capturing = 1'b1;
            hunt_window = '0;
         end else begin
            hunt_window = {hunt_window[7:0], b};
         end
      end else begin
         e.in_frame = 1'b1;
         off = next_offset;
         e.byte_offset = next_offset;
         case (off)
            4:  hdr_id[7:0] = b;
            5:  hdr_id[15:8] = b;
            6:  hdr_fmt = b[5:4];
            8:  hdr_len[7:0] = b;
            9:  hdr_len[15:8] = b;
            14: hdr_week[7:0] = b;
            15: hdr_week[15:8] = b;
            16: hdr_ms[7:0] = b;
            17: hdr_ms[15:8] = b;
            18: hdr_ms[23:16] = b;
            19: hdr_ms[31:24] = b;
            default: ;
         endcase
         body_end = 32'(hdr_len) + HDR_LEN;
         if (off < body_end) begin
            crc_run = crc_next(crc_run, b);
         end else begin
            crc_rx = crc_rx | (32'(b) << (8 * ((off - body_end) & 3)));
         end
         if (off == 9 && 32'(hdr_len) + OVERHEAD > 32'(frame_limit)) begin
            e.frame_end = 1'b1;
            e.status = STATUS_TOO_LONG;
         end else if (off >= HDR_LEN && off >= body_end + 3) begin
            e.frame_end = 1'b1;
            e.status = (crc_run == crc_rx) ? STATUS_GOOD : STATUS_CRC_BAD;
         end
         if (e.frame_end) begin
            capturing = 1'b0;
            next_offset = '0;
            hunt_window = '0;
         end else begin
            next_offset = 17'(off + 1);
         end
      end
      if (e.in_frame) begin
         e.msg_id = hdr_id;
         e.payload_len = hdr_len;
         e.msg_format = hdr_fmt;
         e.gps_week = hdr_week;
         e.gps_ms = hdr_ms;
      end
      expected_echoes.push_back(e);
   endtask

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (!src_idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   function automatic logic [15:0] pick16();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic send_byte(input logic [7:0] b);
      int unsigned gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.rx_byte <= b;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      track_frame_byte(b);
      bytes_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_echoes.size() != 0) @(posedge clock);
   endtask

   task automatic set_frame_limit(input logic [16:0] v);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.max_frame_len <= v;
      @(posedge clock);
      while (csr_ch.ready !== 1'b1) @(posedge clock);
      frame_limit = v;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // fills frame_buf; without a body only the header is built
   task automatic build_frame(input logic [15:0] id, input logic [1:0] fmt,
                              input logic [15:0] len, input logic [15:0] week,
                              input logic [31:0] ms, input bit corrupt,
                              input bit with_body, input bit embed_sync);
      logic [7:0]  hdr[HDR_LEN];
      logic [31:0] c;
      frame_buf.delete();
      for (int i = 0; i < HDR_LEN; i++) hdr[i] = 8'($urandom_range(0, 255));
      hdr[0] = SYNC0;
      hdr[1] = SYNC1;
      hdr[2] = SYNC2;
      hdr[4] = id[7:0];
      hdr[5] = id[15:8];
      hdr[6][5:4] = fmt;
      hdr[8] = len[7:0];
      hdr[9] = len[15:8];
      hdr[14] = week[7:0];
      hdr[15] = week[15:8];
      for (int i = 0; i < 4; i++) hdr[16 + i] = ms[8*i +: 8];
      for (int i = 0; i < HDR_LEN; i++) frame_buf.push_back(hdr[i]);
      if (!with_body) return;
      for (int i = 0; i < int'(len); i++) begin
         if (embed_sync && i < 3) begin
            frame_buf.push_back((i == 0) ? SYNC0 : (i == 1) ? SYNC1 : SYNC2);
         end else begin
            frame_buf.push_back(8'($urandom_range(0, 255)));
         end
      end
      c = '0;
      foreach (frame_buf[i]) c = crc_next(c, frame_buf[i]);
      if (corrupt) c = c ^ (32'd1 << $urandom_range(0, 31));
      for (int i = 0; i < 4; i++) frame_buf.push_back(c[8*i +: 8]);
   endtask

   task automatic send_frame(input int unsigned count);
      int unsigned pause_at;
      pause_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, count - 1) : count;
      for (int unsigned i = 0; i < count; i++) begin
         if (i == pause_at) wait_drained();
         send_byte(frame_buf[i]);
      end
   endtask

   // random bytes until the block is back to hunting
   task automatic flush_capture();
      while (capturing) send_byte(8'($urandom_range(0, 255)));
   endtask

   task automatic send_random_frame();
      int unsigned lim;
      int unsigned len;
      int unsigned min_bad;
      bit          can_pass;
      bit          can_fail;
      flush_capture();
      lim = frame_limit;
      can_pass = lim >= OVERHEAD;
      min_bad = can_pass ? lim - OVERHEAD + 1 : 0;
      can_fail = min_bad <= 65535;
      if (can_pass && ($urandom_range(0, 99) < 85 || !can_fail)) begin
         len = $urandom_range(0, (lim - OVERHEAD < 48) ? lim - OVERHEAD : 48);
         build_frame(pick16(), 2'($urandom_range(0, 3)), 16'(len), pick16(),
                     {pick16(), pick16()}, $urandom_range(0, 3) == 0, 1'b1,
                     $urandom_range(0, 9) == 0);
         send_frame(frame_buf.size());
      end else begin
         len = $urandom_range(min_bad, 65535);
         build_frame(pick16(), 2'($urandom_range(0, 3)), 16'(len), pick16(),
                     {pick16(), pick16()}, 1'b0, 1'b0, 1'b0);
         send_frame(10);
      end
   endtask

   // frame cut short after its length field, the rest is noise
   task automatic send_broken_frame();
      flush_capture();
      build_frame(pick16(), 2'($urandom_range(0, 3)), 16'($urandom_range(0, 12)), pick16(),
                  {pick16(), pick16()}, 1'b0, 1'b1, 1'b0);
      send_frame($urandom_range(10, frame_buf.size() - 1));
   endtask

   task automatic send_noise();
      int unsigned n;
      n = $urandom_range(1, 12);
      repeat (n) begin
         case ($urandom_range(0, 9))
            0: send_byte(SYNC0);
            1: send_byte(SYNC1);
            default: send_byte(8'($urandom_range(0, 255)));
         endcase
      end
   endtask

   task automatic test_default_limit();
      // one byte over the reset limit aborts, a short frame runs to the crc
      build_frame(16'h0101, 2'd1, 16'd10209, 16'h0202, 32'h03030303, 1'b0, 1'b0, 1'b0);
      send_frame(10);
      build_frame(16'h1234, 2'd0, 16'd20, 16'h0800, 32'h12345678, 1'b0, 1'b1, 1'b0);
      send_frame(frame_buf.size());
      wait_drained();
   endtask

   task automatic test_hunting_and_header();
      logic [7:0] lead_in[10];
      lead_in = '{8'h00, 8'hFF, SYNC2, SYNC0, SYNC2, SYNC1, SYNC2, SYNC0, SYNC1, SYNC0};
      foreach (lead_in[i]) send_byte(lead_in[i]);
      // zero payload, header fields at their maximum
      build_frame(16'hFFFF, 2'd3, 16'd0, 16'hFFFF, 32'hFFFFFFFF, 1'b0, 1'b1, 1'b0);
      send_frame(frame_buf.size());
      build_frame(16'h0000, 2'd0, 16'd2, 16'h0000, 32'h00000000, 1'b1, 1'b1, 1'b0);
      send_frame(frame_buf.size());
      // sync pattern inside the payload is plain data
      build_frame(16'h5AA5, 2'd2, 16'd5, 16'h0A5A, 32'h5A5AA5A5, 1'b0, 1'b1, 1'b1);
      send_frame(frame_buf.size());
      // length bytes AA 44 abort the frame; the following 12 must not sync
      build_frame(16'h0042, 2'd1, 16'h44AA, 16'h0001, 32'h00000001, 1'b0, 1'b0, 1'b0);
      send_frame(10);
      send_byte(SYNC2);
      send_byte(SYNC2);
      wait_drained();
   endtask

   task automatic test_limit_extremes();
      set_frame_limit(17'd0);
      build_frame(16'h0001, 2'd0, 16'd0, 16'h0001, 32'h1, 1'b0, 1'b0, 1'b0);
      send_frame(10);
      wait_drained();
      set_frame_limit(17'd32);
      build_frame(16'h0002, 2'd0, 16'd0, 16'h0002, 32'h2, 1'b0, 1'b1, 1'b0);
      send_frame(frame_buf.size());
      build_frame(16'h0003, 2'd0, 16'd1, 16'h0003, 32'h3, 1'b0, 1'b0, 1'b0);
      send_frame(10);
      wait_drained();
      set_frame_limit(17'h1FFFF);
      build_frame(16'h8000, 2'd2, 16'd7, 16'h8000, 32'h80000000, 1'b0, 1'b1, 1'b0);
      send_frame(frame_buf.size());
      wait_drained();
      set_frame_limit(17'd65566);
      build_frame(16'hFFFF, 2'd3, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 1'b0, 1'b0, 1'b0);
      send_frame(10);
      wait_drained();
      // smallest limit that admits every payload length, with a short frame
      set_frame_limit(17'd65567);
      build_frame(16'hFFFF, 2'd3, 16'd40, 16'hFFFF, 32'hFFFFFFFF, 1'b0, 1'b1, 1'b0);
      send_frame(frame_buf.size());
      wait_drained();
   endtask

   task automatic test_random_traffic();
      int unsigned phase_start;
      for (int ph = 0; ph < 6; ph++) begin
         flush_capture();
         wait_drained();
         case (ph)
            0: set_frame_limit(17'd32);
            1: set_frame_limit(17'($urandom_range(0, 31)));
            2: set_frame_limit(17'($urandom_range(33, 120)));
            3: set_frame_limit(17'd65567);
            4: set_frame_limit(17'($urandom_range(32, 65567)));
            default: set_frame_limit(17'h1FFFF);
         endcase
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PHASE_BYTES) begin
            src_idle_on = $urandom_range(0, 3) != 0;
            sink_stall_on = $urandom_range(0, 3) != 0;
            case ($urandom_range(0, 9))
               0: send_noise();
               1: send_broken_frame();
               default: send_random_frame();
            endcase
         end
      end
      flush_capture();
   endtask

   always @(negedge clock) begin
      if (sink_hold != 0) begin
         sink_hold--;
         rsp_ch.ready <= 1'b0;
      end else if (sink_stall_on && $urandom_range(0, 99) < 30) begin
         sink_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 30) : $urandom_range(0, 2);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (expected_echoes.size() == 0) begin
            $error("response with no request pending, data_byte %h", rsp_ch.data_byte);
            mismatch_count++;
         end else begin
            oldest_echo = expected_echoes.pop_front();
            if (rsp_ch.data_byte !== oldest_echo.data_byte) begin
               $error("data_byte: expected %h, actual %h",
                      oldest_echo.data_byte, rsp_ch.data_byte);
               mismatch_count++;
            end
            if (rsp_ch.in_frame !== oldest_echo.in_frame) begin
               $error("in_frame: expected %b, actual %b",
                      oldest_echo.in_frame, rsp_ch.in_frame);
               mismatch_count++;
            end
            if (rsp_ch.byte_offset !== oldest_echo.byte_offset) begin
               $error("byte_offset: expected %0d, actual %0d",
                      oldest_echo.byte_offset, rsp_ch.byte_offset);
               mismatch_count++;
            end
            if (rsp_ch.frame_end !== oldest_echo.frame_end) begin
               $error("frame_end: expected %b, actual %b",
                      oldest_echo.frame_end, rsp_ch.frame_end);
               mismatch_count++;
            end
            if (rsp_ch.status !== oldest_echo.status) begin
               $error("status: expected %0d, actual %0d", oldest_echo.status, rsp_ch.status);
               mismatch_count++;
            end
            if (rsp_ch.msg_id !== oldest_echo.msg_id) begin
               $error("msg_id: expected %h, actual %h", oldest_echo.msg_id, rsp_ch.msg_id);
               mismatch_count++;
            end
            if (rsp_ch.payload_len !== oldest_echo.payload_len) begin
               $error("payload_len: expected %0d, actual %0d",
                      oldest_echo.payload_len, rsp_ch.payload_len);
               mismatch_count++;
            end
            if (rsp_ch.msg_format !== oldest_echo.msg_format) begin
               $error("msg_format: expected %0d, actual %0d",
                      oldest_echo.msg_format, rsp_ch.msg_format);
               mismatch_count++;
            end
            if (rsp_ch.gps_week !== oldest_echo.gps_week) begin
               $error("gps_week: expected %h, actual %h",
                      oldest_echo.gps_week, rsp_ch.gps_week);
               mismatch_count++;
            end
            if (rsp_ch.gps_ms !== oldest_echo.gps_ms) begin
               $error("gps_ms: expected %h, actual %h", oldest_echo.gps_ms, rsp_ch.gps_ms);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.rx_byte = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.max_frame_len = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_default_limit();
      test_hunting_and_header();
      test_limit_extremes();
      test_random_traffic();
      wait_drained();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && expected_echoes.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* filelist.f */
sv/slcfc_pkg.sv
sv/slcfc_if.sv
sv/sync_length_crc32_frame_checker.sv
sv/slcfc_checker.sv
tb/tb_sync_length_crc32_frame_checker.sv
